// ===== hdl/sdps_pkg.sv =====
// Shared types and constants for the star-delta pulse motor starter.
package sdps_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_START_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STAR_TICKS      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_ON_TICKS  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_OFF_TICKS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TOTAL     = 3'd4;

	// Register values after reset.
	localparam logic        RST_START_MODE      = 1'b0;
	localparam logic [7:0]  RST_STAR_TICKS      = 8'd25;
	localparam logic [15:0] RST_PULSE_ON_TICKS  = 16'd3;
	localparam logic [15:0] RST_PULSE_OFF_TICKS = 16'd3;
	localparam logic [7:0]  RST_PULSE_TOTAL     = 8'd5;

	// Start modes.
	localparam logic MODE_DIRECT = 1'b0;
	localparam logic MODE_PULSE  = 1'b1;

	// Run phases.
	localparam logic [1:0] PH_STOPPED = 2'd0;
	localparam logic [1:0] PH_START   = 2'd1;
	localparam logic [1:0] PH_DELTA   = 2'd2;

	// Drive level bits.
	localparam logic [2:0] LV_MAIN  = 3'b001;
	localparam logic [2:0] LV_STAR  = 3'b010;
	localparam logic [2:0] LV_DELTA = 3'b100;

	typedef struct packed {
		logic stop_released;
		logic start_pressed;
	} in_item_t;

	typedef struct packed {
		logic       main_on;
		logic       star_on;
		logic       delta_on;
		logic [1:0] run_phase;
		logic [7:0] pulses_done;
	} out_item_t;

endpackage

// ===== hdl/star_delta_pulse_motor_starter.sv =====
// Star-delta motor starter with pulsed jog start: one control tick per input transfer.
// Each accepted input transfer is one control tick. The tick is evaluated in the
// cycle it is accepted against the stored run state and configuration, and its
// result is registered into the output register, or into the skid register while
// the output is held. The block takes one tick every clock; a two-entry output
// stage (result register plus a skid register) lets it accept a tick while an
// earlier result waits, and the input stalls only once both entries hold results.
// Configuration writes take effect at the clock edge of the write.
module star_delta_pulse_motor_starter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [sdps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  sdps_pkg::in_item_t                   in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output sdps_pkg::out_item_t                  out_item
);

	// Configuration registers.
	logic        start_mode_q;
	logic [7:0]  star_ticks_q;
	logic [15:0] pulse_on_ticks_q;
	logic [15:0] pulse_off_ticks_q;
	logic [7:0]  pulse_total_q;

	// Run state.
	logic [1:0]  phase_q;
	logic        latch_q;
	logic [15:0] star_cnt_q;
	logic [15:0] on_cnt_q;
	logic [15:0] off_cnt_q;
	logic [7:0]  pulse_cnt_q;
	logic [2:0]  lv_q;

	// Next run state.
	logic [1:0]  phase_d;
	logic        latch_d;
	logic [15:0] star_cnt_d;
	logic [15:0] on_cnt_d;
	logic [15:0] off_cnt_d;
	logic [7:0]  pulse_cnt_d;
	logic [2:0]  lv_d;
	logic        jogging;

	// Output stage.
	logic                out_valid_q;
	logic                skid_valid_q;
	sdps_pkg::out_item_t out_item_q;
	sdps_pkg::out_item_t skid_item_q;
	sdps_pkg::out_item_t result;

	logic in_xfer;
	logic out_xfer;
	logic out_free;

	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mode_q      <= sdps_pkg::RST_START_MODE;
			star_ticks_q      <= sdps_pkg::RST_STAR_TICKS;
			pulse_on_ticks_q  <= sdps_pkg::RST_PULSE_ON_TICKS;
			pulse_off_ticks_q <= sdps_pkg::RST_PULSE_OFF_TICKS;
			pulse_total_q     <= sdps_pkg::RST_PULSE_TOTAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdps_pkg::REG_START_MODE:      start_mode_q      <= cfg_data[0];
				sdps_pkg::REG_STAR_TICKS:      star_ticks_q      <= cfg_data[7:0];
				sdps_pkg::REG_PULSE_ON_TICKS:  pulse_on_ticks_q  <= cfg_data;
				sdps_pkg::REG_PULSE_OFF_TICKS: pulse_off_ticks_q <= cfg_data;
				sdps_pkg::REG_PULSE_TOTAL:     pulse_total_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// One tick of the starter. The steps follow each other in the order the
	// controller evaluates them, so later steps see the earlier updates.
	always_comb begin
		phase_d     = phase_q;
		latch_d     = latch_q;
		star_cnt_d  = star_cnt_q;
		on_cnt_d    = on_cnt_q;
		off_cnt_d   = off_cnt_q;
		pulse_cnt_d = pulse_cnt_q;
		lv_d        = lv_q;
		jogging     = 1'b0;

		if (!in_item.stop_released) begin
			phase_d = sdps_pkg::PH_STOPPED;
		end
		if (in_item.start_pressed && in_item.stop_released && !latch_q) begin
			phase_d = sdps_pkg::PH_START;
			latch_d = 1'b1;
		end

		if (start_mode_q == sdps_pkg::MODE_DIRECT) begin
			if (phase_d == sdps_pkg::PH_START) begin
				lv_d       = sdps_pkg::LV_MAIN | sdps_pkg::LV_STAR;
				star_cnt_d = star_cnt_q + 16'd1;
				if (star_cnt_d == {8'd0, star_ticks_q}) begin
					phase_d    = sdps_pkg::PH_DELTA;
					star_cnt_d = '0;
				end
			end
			if (phase_d == sdps_pkg::PH_DELTA) begin
				lv_d = sdps_pkg::LV_MAIN | sdps_pkg::LV_DELTA;
			end
			if (phase_d == sdps_pkg::PH_STOPPED) begin
				lv_d       = '0;
				star_cnt_d = '0;
				latch_d    = 1'b0;
			end
		end else begin
			jogging = (phase_d == sdps_pkg::PH_START) && (pulse_cnt_q != pulse_total_q);
			if (pulse_cnt_q == pulse_total_q) begin
				lv_d = lv_d | sdps_pkg::LV_MAIN;
			end
			if (jogging && off_cnt_q == 16'd0) begin
				lv_d     = lv_d | sdps_pkg::LV_MAIN;
				on_cnt_d = on_cnt_q + 16'd1;
			end
			if (jogging && on_cnt_d == pulse_on_ticks_q) begin
				lv_d      = lv_d & ~sdps_pkg::LV_MAIN;
				off_cnt_d = off_cnt_q + 16'd1;
			end
			if (jogging && off_cnt_d == pulse_off_ticks_q) begin
				on_cnt_d    = '0;
				off_cnt_d   = '0;
				pulse_cnt_d = pulse_cnt_q + 8'd1;
			end
			if (phase_d == sdps_pkg::PH_STOPPED) begin
				lv_d        = '0;
				latch_d     = 1'b0;
				on_cnt_d    = '0;
				off_cnt_d   = '0;
				pulse_cnt_d = '0;
			end
		end

		result.main_on     = |(lv_d & sdps_pkg::LV_MAIN);
		result.star_on     = |(lv_d & sdps_pkg::LV_STAR);
		result.delta_on    = |(lv_d & sdps_pkg::LV_DELTA);
		result.run_phase   = phase_d;
		result.pulses_done = pulse_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdps_pkg::PH_STOPPED;
			latch_q     <= 1'b0;
			star_cnt_q  <= '0;
			on_cnt_q    <= '0;
			off_cnt_q   <= '0;
			pulse_cnt_q <= '0;
			lv_q        <= '0;
		end else if (in_xfer) begin
			phase_q     <= phase_d;
			latch_q     <= latch_d;
			star_cnt_q  <= star_cnt_d;
			on_cnt_q    <= on_cnt_d;
			off_cnt_q   <= off_cnt_d;
			pulse_cnt_q <= pulse_cnt_d;
			lv_q        <= lv_d;
		end
	end

	// The skid register only fills when a result arrives while the output
	// register is held; it drains into the output register first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_item_q <= skid_item_q;
			end
		end else if (in_xfer) begin
			if (out_free) begin
				out_item_q <= result;
			end else begin
				skid_item_q <= result;
			end
		end
	end

endmodule

// ===== hdl/sdps_checker.sv =====
// Port-level checker for the star-delta pulse motor starter, with its bind.
module sdps_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input sdps_pkg::out_item_t out_item
);

	// A stopped starter drives no contactor.
	a_stopped_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.run_phase == sdps_pkg::PH_STOPPED
		|-> !out_item.main_on && !out_item.star_on && !out_item.delta_on)
		else $error("contactor driven while stopped");

	// Star and delta must never close together.
	a_star_delta_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.star_on && out_item.delta_on))
		else $error("star and delta driven together");

	// The run phase never takes the unused code.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.run_phase <= sdps_pkg::PH_DELTA)
		else $error("run phase out of range");

	// A held result stays put until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

endmodule

bind star_delta_pulse_motor_starter sdps_checker u_sdps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
